@@ rtl/ppml_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppml_pkg
// Shared widths, register map, reset values and controller/datapath links
// for the proportional position motor loop.
// ----------------------------------------------------------------------------
package ppml_pkg;

    // Field widths fixed by the interface
    localparam int POS_PORT_W    = 32;
    localparam int ERR_W         = 32;
    localparam int GAIN_W        = 8;
    localparam int DUTY_W        = 8;
    localparam int THRESH_W      = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // Default for the position width parameter
    localparam int POSITION_WIDTH_DEF = 32;

    // Divider: product of gain numerator and error magnitude
    localparam int PROD_W        = GAIN_W + ERR_W;
    localparam int DIV_STEPS     = PROD_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP_NUMER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_DENOM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_ERROR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_CHANGE = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0]   KP_NUMER_RST      = 8'd3;
    localparam logic [GAIN_W-1:0]   KP_DENOM_RST      = 8'd128;
    localparam logic [DUTY_W-1:0]   PWM_MIN_RST       = 8'd100;
    localparam logic [DUTY_W-1:0]   PWM_MAX_RST       = 8'd250;
    localparam logic [THRESH_W-1:0] SETTLE_ERROR_RST  = 16'd100;
    localparam logic [THRESH_W-1:0] SETTLE_CHANGE_RST = 16'd10;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Saturation limits of the error
    localparam logic [ERR_W-1:0] ERR_POS_LIMIT = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic [ERR_W-1:0] ERR_NEG_LIMIT = {1'b1, {(ERR_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0]   kp_numer;
        logic [GAIN_W-1:0]   kp_denom;
        logic [DUTY_W-1:0]   pwm_min;
        logic [DUTY_W-1:0]   pwm_max;
        logic [THRESH_W-1:0] settle_error;
        logic [THRESH_W-1:0] settle_change;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic mul;
        logic div_step;
        logic clamp;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } ctrl_status_t;

endpackage
`default_nettype wire

@@ rtl/ppml_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppml_regs
// Configuration register file: gain, duty limits and settle thresholds.
// ----------------------------------------------------------------------------
module ppml_regs (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ppml_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [ppml_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ppml_pkg::cfg_t                      cfg
);

    ppml_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_numer      <= ppml_pkg::KP_NUMER_RST;
            cfg_reg.kp_denom      <= ppml_pkg::KP_DENOM_RST;
            cfg_reg.pwm_min       <= ppml_pkg::PWM_MIN_RST;
            cfg_reg.pwm_max       <= ppml_pkg::PWM_MAX_RST;
            cfg_reg.settle_error  <= ppml_pkg::SETTLE_ERROR_RST;
            cfg_reg.settle_change <= ppml_pkg::SETTLE_CHANGE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ppml_pkg::REG_KP_NUMER: begin
                    cfg_reg.kp_numer <= cfg_data[ppml_pkg::GAIN_W-1:0];
                end
                ppml_pkg::REG_KP_DENOM: begin
                    cfg_reg.kp_denom <= cfg_data[ppml_pkg::GAIN_W-1:0];
                end
                ppml_pkg::REG_PWM_MIN: begin
                    cfg_reg.pwm_min <= cfg_data[ppml_pkg::DUTY_W-1:0];
                end
                ppml_pkg::REG_PWM_MAX: begin
                    cfg_reg.pwm_max <= cfg_data[ppml_pkg::DUTY_W-1:0];
                end
                ppml_pkg::REG_SETTLE_ERROR: begin
                    cfg_reg.settle_error <= cfg_data;
                end
                ppml_pkg::REG_SETTLE_CHANGE: begin
                    cfg_reg.settle_change <= cfg_data;
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/ppml_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppml_ctrl
// Sequencer: accept, evaluate, multiply, divide bit by bit, clamp, deliver.
// ----------------------------------------------------------------------------
module ppml_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  ppml_pkg::ctrl_status_t status,
    output ppml_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_CLAMP,
        ST_OUT
    } state_t;

    localparam logic [ppml_pkg::DIV_CNT_W-1:0] DIV_LAST =
        ppml_pkg::DIV_CNT_W'(ppml_pkg::DIV_STEPS - 1);

    state_t                          state_reg;
    logic [ppml_pkg::DIV_CNT_W-1:0]  cnt_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && s_valid;
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.clamp    = (state_reg == ST_CLAMP);
        cmd.out_load = (state_reg == ST_OUT) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    state_reg <= status.need_div ? ST_MUL : ST_OUT;
                end
                ST_MUL: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_CLAMP;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_CLAMP: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (status.out_free) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/ppml_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppml_dpath
// Loop state, error and settle logic, gain multiply, restoring divider,
// duty clamp and the result register.
// ----------------------------------------------------------------------------
module ppml_dpath #(
    parameter int POSITION_WIDTH = ppml_pkg::POSITION_WIDTH_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  ppml_pkg::ctrl_cmd_t                 cmd,
    output ppml_pkg::ctrl_status_t              status,
    input  ppml_pkg::cfg_t                      cfg,
    input  wire                                 s_cmd,
    input  wire  signed [ppml_pkg::POS_PORT_W-1:0] s_target,
    input  wire  signed [ppml_pkg::POS_PORT_W-1:0] s_position,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [ppml_pkg::DUTY_W-1:0]         m_pwm_duty,
    output logic                                m_dir_a,
    output logic                                m_dir_b,
    output logic                                m_standby,
    output logic                                m_done_res,
    output logic                                m_clear_position,
    output logic signed [ppml_pkg::ERR_W-1:0]   m_error_out
);

    localparam int EW    = (POSITION_WIDTH > ppml_pkg::POS_PORT_W) ?
                           ppml_pkg::POS_PORT_W : POSITION_WIDTH;
    localparam int ERR_W = ppml_pkg::ERR_W;
    localparam int DW    = ERR_W + 1;
    localparam int PW    = ppml_pkg::PROD_W;
    localparam int GW    = ppml_pkg::GAIN_W;

    // latched input word
    logic                 cmd_in_reg;
    logic [EW-1:0]        tgt_reg;
    logic [EW-1:0]        pos_reg;

    // loop state
    logic                 active_reg;
    logic [EW-1:0]        goal_reg;
    logic [ERR_W-1:0]     prev_err_reg;
    logic                 dir_a_reg;
    logic                 dir_b_reg;
    logic                 en_reg;

    // work registers
    logic [ERR_W-1:0]     err_reg;
    logic [ERR_W-1:0]     mag_reg;
    logic [PW-1:0]        quo_reg;
    logic [GW-1:0]        rem_reg;
    logic [ppml_pkg::DUTY_W-1:0] duty_reg;
    logic                 done_reg;
    logic                 clr_reg;

    // error and settle logic
    logic [DW-1:0]        goal_ext;
    logic [DW-1:0]        pos_ext;
    logic [DW-1:0]        diff;
    logic [ERR_W-1:0]     err_sat;
    logic [DW-1:0]        change;
    logic [DW-1:0]        change_mag;
    logic [ERR_W-1:0]     err_mag;
    logic                 settled;

    assign goal_ext = {{(DW-EW){goal_reg[EW-1]}}, goal_reg};
    assign pos_ext  = {{(DW-EW){pos_reg[EW-1]}}, pos_reg};
    assign diff     = goal_ext - pos_ext;

    always_comb begin
        if (diff[DW-1] != diff[DW-2]) begin
            err_sat = diff[DW-1] ? ppml_pkg::ERR_NEG_LIMIT : ppml_pkg::ERR_POS_LIMIT;
        end else begin
            err_sat = diff[ERR_W-1:0];
        end
    end

    assign change     = {prev_err_reg[ERR_W-1], prev_err_reg} - {err_sat[ERR_W-1], err_sat};
    assign change_mag = change[DW-1] ? (~change + 1'b1) : change;
    assign err_mag    = err_sat[ERR_W-1] ? (~err_sat + 1'b1) : err_sat;
    assign settled    = (change_mag < DW'(cfg.settle_change)) &&
                        (err_mag < ERR_W'(cfg.settle_error));

    assign status.need_div = (cmd_in_reg == ppml_pkg::CMD_TICK) && active_reg && !settled;
    assign status.out_free = !m_valid || m_ready;

    // restoring divider step
    logic [GW:0]          rem_sh;
    logic                 fits;
    logic [GW:0]          rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[PW-1]};
    assign fits    = (rem_sh >= {1'b0, cfg.kp_denom});
    assign rem_sub = rem_sh - {1'b0, cfg.kp_denom};

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_in_reg <= s_cmd;
            tgt_reg    <= s_target[EW-1:0];
            pos_reg    <= s_position[EW-1:0];
        end

        if (cmd.eval) begin
            err_reg  <= '0;
            duty_reg <= '0;
            done_reg <= 1'b0;
            clr_reg  <= 1'b0;
            mag_reg  <= err_mag;
            if (cmd_in_reg == ppml_pkg::CMD_TICK && active_reg) begin
                err_reg <= err_sat;
                if (settled) begin
                    done_reg <= 1'b1;
                    clr_reg  <= 1'b1;
                end
            end
        end

        if (cmd.mul) begin
            quo_reg <= PW'(cfg.kp_numer * mag_reg);
            rem_reg <= '0;
        end

        if (cmd.div_step) begin
            quo_reg <= {quo_reg[PW-2:0], fits};
            rem_reg <= fits ? rem_sub[GW-1:0] : rem_sh[GW-1:0];
        end

        if (cmd.clamp) begin
            if (quo_reg < PW'(cfg.pwm_min)) begin
                duty_reg <= cfg.pwm_min;
            end else if (quo_reg > PW'(cfg.pwm_max)) begin
                duty_reg <= cfg.pwm_max;
            end else begin
                duty_reg <= quo_reg[ppml_pkg::DUTY_W-1:0];
            end
        end

        if (cmd.out_load) begin
            m_pwm_duty       <= duty_reg;
            m_dir_a          <= dir_a_reg;
            m_dir_b          <= dir_b_reg;
            m_standby        <= en_reg;
            m_done_res       <= done_reg;
            m_clear_position <= clr_reg;
            m_error_out      <= err_reg;
        end
    end

    // loop state and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            goal_reg     <= '0;
            prev_err_reg <= '0;
            dir_a_reg    <= 1'b0;
            dir_b_reg    <= 1'b0;
            en_reg       <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            if (cmd.eval) begin
                if (cmd_in_reg == ppml_pkg::CMD_START) begin
                    goal_reg     <= tgt_reg;
                    prev_err_reg <= '0;
                    en_reg       <= 1'b1;
                    active_reg   <= 1'b1;
                end else if (active_reg) begin
                    prev_err_reg <= err_sat;
                    if (settled) begin
                        dir_a_reg  <= 1'b0;
                        dir_b_reg  <= 1'b0;
                        active_reg <= 1'b0;
                    end else if (!err_sat[ERR_W-1] && (err_sat != '0)) begin
                        dir_a_reg <= 1'b0;
                        dir_b_reg <= 1'b1;
                    end else if (err_sat[ERR_W-1]) begin
                        dir_a_reg <= 1'b1;
                        dir_b_reg <= 1'b0;
                    end
                end
            end

            if (cmd.out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/proportional_position_motor_loop.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// proportional_position_motor_loop
// Proportional position loop for an encoder DC motor with a clamped PWM duty.
// ----------------------------------------------------------------------------
// One input word gives one result word. A start word (cmd 0) loads the
// target, clears the last error, raises standby and arms the loop; it and
// any tick that needs no duty (loop idle, or the move settling) go from
// idle through evaluate straight to the output state. A driving tick runs
// through evaluate (the saturated error and the settle test), the gain
// multiply, the one-bit-per-cycle restoring divider that forms
// kp_numer*|error|/kp_denom, the duty clamp and the output state that
// loads the result register, and then back to idle. The result register
// lets the next word in while a result waits; a further result waits for
// it to drain. Only the low min(POSITION_WIDTH, 32) bits of target and
// position are used, as signed values. Configuration writes are taken on
// any cycle and must be made while the block is idle; unmapped indexes
// are dropped. A divisor of zero drives the duty to pwm_max.
// ----------------------------------------------------------------------------
module proportional_position_motor_loop #(
    parameter int POSITION_WIDTH = ppml_pkg::POSITION_WIDTH_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,

    // configuration write channel
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [ppml_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [ppml_pkg::CFG_DATA_W-1:0]        cfg_data,

    // input words
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire                                    s_cmd,
    input  wire  signed [ppml_pkg::POS_PORT_W-1:0] s_target,
    input  wire  signed [ppml_pkg::POS_PORT_W-1:0] s_position,

    // result words
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic [ppml_pkg::DUTY_W-1:0]            m_pwm_duty,
    output logic                                   m_dir_a,
    output logic                                   m_dir_b,
    output logic                                   m_standby,
    output logic                                   m_done_res,
    output logic                                   m_clear_position,
    output logic signed [ppml_pkg::ERR_W-1:0]      m_error_out
);

    ppml_pkg::cfg_t         cfg;
    ppml_pkg::ctrl_cmd_t    cmd;
    ppml_pkg::ctrl_status_t status;

    // register file: hold gain, limits and thresholds
    ppml_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: advance one word through evaluate, multiply, divide, clamp
    ppml_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: loop state, arithmetic and the result register
    ppml_dpath #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg),
        .s_cmd            (s_cmd),
        .s_target         (s_target),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pwm_duty       (m_pwm_duty),
        .m_dir_a          (m_dir_a),
        .m_dir_b          (m_dir_b),
        .m_standby        (m_standby),
        .m_done_res       (m_done_res),
        .m_clear_position (m_clear_position),
        .m_error_out      (m_error_out)
    );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the proportional position motor loop.
// ----------------------------------------------------------------------------
// Input words go in over valid/ready in random bursts while the result side
// stalls on a pattern of its own. Every accepted word runs through a local
// model of the loop (target, last error, direction levels, standby, gains
// and clamp limits). Each result word is checked field by field against the
// oldest queued prediction. Register writes happen only with the block idle.
// ----------------------------------------------------------------------------
module testbench;
    import ppml_pkg::*;

    // Run length guard and the idle pause before any register write
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_GUARD  = 60;
    localparam int RANDOM_WORDS_PER_SETTING = 80;
    localparam int RANDOM_SETTINGS = 5;

    // Indexes that map to no register, written to see them dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // Position extremes of the signed 32-bit fields
    localparam logic [POS_PORT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_PORT_W-1:0] POS_MIN = 32'h8000_0000;

    // Error saturation bounds as 64-bit signed numbers
    localparam longint ERR_MAX = longint'(signed'(ERR_POS_LIMIT));
    localparam longint ERR_MIN = longint'(signed'(ERR_NEG_LIMIT));

    typedef struct packed {
        logic [DUTY_W-1:0]       pwm_duty;
        logic                    dir_a;
        logic                    dir_b;
        logic                    standby;
        logic                    done_res;
        logic                    clear_position;
        logic signed [ERR_W-1:0] error_out;
    } drive_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_word_t;

    // Clock, reset and block ports; every input starts at a known level
    logic                         aclk    = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic                         s_cmd      = CMD_TICK;
    logic signed [POS_PORT_W-1:0] s_target   = '0;
    logic signed [POS_PORT_W-1:0] s_position = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [DUTY_W-1:0]            m_pwm_duty;
    logic                         m_dir_a;
    logic                         m_dir_b;
    logic                         m_standby;
    logic                         m_done_res;
    logic                         m_clear_position;
    logic signed [ERR_W-1:0]      m_error_out;

    // Local copy of the loop state and its registers
    cfg_t regs = '{kp_numer: KP_NUMER_RST, kp_denom: KP_DENOM_RST,
                   pwm_min: PWM_MIN_RST, pwm_max: PWM_MAX_RST,
                   settle_error: SETTLE_ERROR_RST, settle_change: SETTLE_CHANGE_RST};
    logic                    armed      = 1'b0;
    logic signed [ERR_W-1:0] goal_pos   = '0;
    longint                  last_err   = 0;
    logic                    lvl_a      = 1'b0;
    logic                    lvl_b      = 1'b0;
    logic                    lvl_enable = 1'b0;

    // Predicted drive words waiting for the block, oldest first
    drive_t    pending_drive[$];
    reg_word_t reg_writes[$];

    int unsigned burst_left   = 0;
    logic        word_held    = 1'b0;
    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned moves_settled = 0;
    int unsigned regs_written = 0;
    int unsigned reg_settings = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    // Result-side stall pattern state
    int unsigned rx_stall = 0;
    logic [9:0]  rx_tick  = '0;

    proportional_position_motor_loop dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_target        (s_target),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_duty      (m_pwm_duty),
        .m_dir_a         (m_dir_a),
        .m_dir_b         (m_dir_b),
        .m_standby       (m_standby),
        .m_done_res      (m_done_res),
        .m_clear_position(m_clear_position),
        .m_error_out     (m_error_out)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Stall the result side: steady-ready stretches while bit 8 of rx_tick is set,
    // otherwise random drops and occasional long stalls.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            m_ready  <= 1'b0;
        end else if (rx_tick[8]) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
            rx_stall <= $urandom_range(1, 20);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Advance the loop model by one accepted word and return its drive word.
    function automatic drive_t next_drive(input logic cmd,
                                          input logic signed [POS_PORT_W-1:0] tgt,
                                          input logic signed [POS_PORT_W-1:0] pos);
        drive_t      d;
        longint      err;
        longint      step;
        logic [63:0] err_mag;
        logic [63:0] step_mag;
        logic [63:0] q;
        logic        settled;
        d   = '0;
        err = 0;
        if (cmd == CMD_START) begin
            goal_pos   = tgt;
            last_err   = 0;
            lvl_enable = 1'b1;
            armed      = 1'b1;
        end else if (armed) begin
            err = longint'(goal_pos) - longint'(pos);
            if (err > ERR_MAX) err = ERR_MAX;
            if (err < ERR_MIN) err = ERR_MIN;
            step     = last_err - err;
            step_mag = (step < 0) ? -step : step;
            err_mag  = (err < 0) ? -err : err;
            settled  = (step_mag < 64'(regs.settle_change)) &&
                       (err_mag < 64'(regs.settle_error));
            last_err = err;
            if (settled) begin
                // Finish the move: pins low, duty off, pulse the counter clear
                lvl_a            = 1'b0;
                lvl_b            = 1'b0;
                d.done_res       = 1'b1;
                d.clear_position = 1'b1;
                armed            = 1'b0;
            end else begin
                // Zero error leaves the pins where they were
                if (err > 0) begin
                    lvl_a = 1'b0;
                    lvl_b = 1'b1;
                end else if (err < 0) begin
                    lvl_a = 1'b1;
                    lvl_b = 1'b0;
                end
                if (regs.kp_denom == '0) begin
                    q = '1;
                end else begin
                    q = (64'(regs.kp_numer) * err_mag) / 64'(regs.kp_denom);
                end
                // Crossed limits fall out of this order of tests
                if (q < 64'(regs.pwm_min)) q = 64'(regs.pwm_min);
                else if (q > 64'(regs.pwm_max)) q = 64'(regs.pwm_max);
                d.pwm_duty = q[DUTY_W-1:0];
            end
        end
        d.dir_a     = lvl_a;
        d.dir_b     = lvl_b;
        d.standby   = lvl_enable;
        d.error_out = err[ERR_W-1:0];
        return d;
    endfunction

    function automatic void apply_reg(input reg_word_t w);
        case (w.idx)
            REG_KP_NUMER:      regs.kp_numer      = w.data[GAIN_W-1:0];
            REG_KP_DENOM:      regs.kp_denom      = w.data[GAIN_W-1:0];
            REG_PWM_MIN:       regs.pwm_min       = w.data[DUTY_W-1:0];
            REG_PWM_MAX:       regs.pwm_max       = w.data[DUTY_W-1:0];
            REG_SETTLE_ERROR:  regs.settle_error  = w.data[THRESH_W-1:0];
            REG_SETTLE_CHANGE: regs.settle_change = w.data[THRESH_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic check_field(input string fname, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result word with the oldest prediction.
    always @(posedge aclk) begin : result_check
        drive_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_drive.size() == 0) begin
                $error("result word arrived with no prediction waiting");
                mismatches++;
            end else begin
                want = pending_drive.pop_front();
                check_field("pwm_duty", 32'(want.pwm_duty), 32'(m_pwm_duty));
                check_field("dir_a", 32'(want.dir_a), 32'(m_dir_a));
                check_field("dir_b", 32'(want.dir_b), 32'(m_dir_b));
                check_field("standby", 32'(want.standby), 32'(m_standby));
                check_field("done_res", 32'(want.done_res), 32'(m_done_res));
                check_field("clear_position", 32'(want.clear_position),
                            32'(m_clear_position));
                check_field("error_out", want.error_out, m_error_out);
                if (want.done_res) moves_settled++;
            end
        end
    end

    // Send one input word. Bursts keep valid high from word to word; a burst
    // ends by dropping valid at the acceptance edge, then a random gap.
    task automatic send_word(input logic cmd, input logic [POS_PORT_W-1:0] tgt,
                             input logic [POS_PORT_W-1:0] pos);
        int unsigned pause;
        if (burst_left == 0) begin
            pause = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(1, 6);
            repeat (pause) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_target   <= tgt;
        s_position <= pos;
        word_held  = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_drive.push_back(next_drive(cmd, tgt, pos));
        words_sent++;
        burst_left--;
        if (burst_left == 0) begin
            s_valid   <= 1'b0;
            word_held = 1'b0;
        end
    endtask

    // Drop valid, wait for every predicted result, then let the block go idle.
    task automatic drain_words();
        if (word_held) begin
            s_valid   <= 1'b0;
            word_held = 1'b0;
        end
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (IDLE_GUARD) @(posedge aclk);
    endtask

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        reg_word_t w;
        w.idx  = idx;
        w.data = data;
        reg_writes.push_back(w);
    endtask

    // Write all queued registers back to back, with the block idle.
    task automatic write_regs();
        reg_word_t w;
        drain_words();
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            do @(posedge aclk); while (!cfg_ready);
            apply_reg(w);
            regs_written++;
        end
        cfg_valid <= 1'b0;
        reg_settings++;
    endtask

    // Random byte register value; upper data bits are junk the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_byte(input int unsigned lo);
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0:       b = 8'(lo);
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(lo, 255));
        endcase
        return {8'($urandom), b};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold(input int unsigned span);
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return '0;
            default: return 16'($urandom_range(1, span));
        endcase
    endfunction

    function automatic longint pick_error();
        longint e;
        case ($urandom_range(0, 3))
            0:       e = longint'($urandom_range(0, 300));
            1:       e = longint'($urandom_range(0, 5000));
            2:       e = longint'($urandom_range(0, 1 << 20));
            default: e = longint'(int'($urandom));
        endcase
        if ($urandom_range(0, 1) != 0) e = -e;
        return e;
    endfunction

    // One well-formed move: start, a run of ticks closing in on the target,
    // then a few ticks parked at one small offset so the loop can settle.
    task automatic run_move();
        logic [POS_PORT_W-1:0] tgt;
        longint                err;
        longint                off;
        int unsigned           n;
        tgt = ($urandom_range(0, 2) == 0) ? $urandom
                                          : POS_PORT_W'(int'($urandom_range(0, 20000)) - 10000);
        send_word(CMD_START, tgt, $urandom);
        err = pick_error();
        n   = $urandom_range(1, 10);
        repeat (n) begin
            send_word(CMD_TICK, $urandom, tgt - err[POS_PORT_W-1:0]);
            err = (err * longint'($urandom_range(0, 7))) / 8
                  + longint'($urandom_range(0, 6)) - 3;
        end
        off = longint'($urandom_range(0, 200)) - 100;
        n   = $urandom_range(1, 3);
        repeat (n) send_word(CMD_TICK, $urandom, tgt - off[POS_PORT_W-1:0]);
    endtask

    task automatic noise_word();
        send_word(($urandom_range(0, 5) == 0) ? CMD_START : CMD_TICK, $urandom, $urandom);
    endtask

    // ---------------------------------------------------------------- tests

    // Ticks before any start: all zero, standby low, nothing changes.
    task automatic test_idle_ticks();
        send_word(CMD_TICK, POS_MAX, POS_MIN);
        send_word(CMD_TICK, POS_MIN, POS_MAX);
    endtask

    // Errors beyond 32 bits saturate in both directions.
    task automatic test_saturation();
        send_word(CMD_START, POS_MAX, '0);
        send_word(CMD_TICK, '0, POS_MIN);
        send_word(CMD_START, POS_MIN, '1);
        send_word(CMD_TICK, '1, POS_MAX);
        send_word(CMD_TICK, '0, '0);
    endtask

    // Duty below the floor, a zero error holding the pins, then settling
    // and an idle tick after the move with standby still high.
    task automatic test_hold_and_settle();
        send_word(CMD_START, 32'd1000, '0);
        send_word(CMD_TICK, '0, 32'd500);
        send_word(CMD_TICK, '0, 32'd1000);
        send_word(CMD_TICK, '0, 32'd1000);
        send_word(CMD_TICK, '0, 32'd1000);
    endtask

    // The first tick of a move judges its change against zero.
    task automatic test_first_tick_settle();
        send_word(CMD_START, -32'sd50, '0);
        send_word(CMD_TICK, '0, -32'sd45);
    endtask

    task automatic test_zero_divisor();
        queue_reg(REG_KP_DENOM, 16'hAB00);
        queue_reg(REG_PWM_MIN, 16'd0);
        queue_reg(REG_PWM_MAX, 16'd255);
        write_regs();
        send_word(CMD_START, '0, '0);
        send_word(CMD_TICK, '0, -32'sd5000);
    endtask

    // pwm_min above pwm_max: below the floor gives the floor, else the ceiling.
    task automatic test_crossed_limits();
        queue_reg(REG_KP_NUMER, 16'd1);
        queue_reg(REG_KP_DENOM, 16'd1);
        queue_reg(REG_PWM_MIN, 16'd200);
        queue_reg(REG_PWM_MAX, 16'd50);
        queue_reg(REG_SETTLE_ERROR, 16'd0);
        write_regs();
        send_word(CMD_START, '0, '0);
        send_word(CMD_TICK, '0, -32'sd100);
        send_word(CMD_TICK, '0, -32'sd250);
        send_word(CMD_TICK, '0, 32'sd150);
    endtask

    // Gain extremes, widest thresholds, junk high bits and unmapped indexes.
    task automatic test_register_edges();
        queue_reg(REG_KP_NUMER, 16'hFF00);
        queue_reg(REG_SPARE_A, 16'hFFFF);
        queue_reg(REG_SPARE_B, 16'h5A5A);
        queue_reg(REG_SETTLE_ERROR, 16'hFFFF);
        queue_reg(REG_SETTLE_CHANGE, 16'd0);
        write_regs();
        send_word(CMD_START, '0, '0);
        send_word(CMD_TICK, '0, -32'sd70000);
        queue_reg(REG_KP_NUMER, 16'hFFFF);
        queue_reg(REG_KP_DENOM, 16'h0101);
        queue_reg(REG_PWM_MIN, 16'hFF00);
        queue_reg(REG_SETTLE_CHANGE, 16'hFFFF);
        write_regs();
        send_word(CMD_START, '0, '0);
        send_word(CMD_TICK, '0, 32'sd70000);
        send_word(CMD_TICK, '0, '0);
    endtask

    // Mostly well-formed moves under several random register settings.
    task automatic test_random_moves();
        int unsigned first;
        repeat (RANDOM_SETTINGS) begin
            queue_reg(REG_KP_NUMER, pick_byte(0));
            queue_reg(REG_KP_DENOM, ($urandom_range(0, 9) == 0) ? '0 : pick_byte(1));
            queue_reg(REG_PWM_MIN, pick_byte(0));
            queue_reg(REG_PWM_MAX, pick_byte(0));
            queue_reg(REG_SETTLE_ERROR, pick_threshold(3000));
            queue_reg(REG_SETTLE_CHANGE, pick_threshold(300));
            if ($urandom_range(0, 1) != 0) begin
                queue_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          16'($urandom));
            end
            write_regs();
            first = words_sent;
            while (words_sent - first < RANDOM_WORDS_PER_SETTING) begin
                if ($urandom_range(0, 4) == 0) noise_word();
                else run_move();
            end
        end
    endtask

    // Timeout: give up if the run never drains.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_ticks();
        test_saturation();
        test_hold_and_settle();
        test_first_tick_settle();
        test_zero_divisor();
        test_crossed_limits();
        test_register_edges();
        test_random_moves();
        drain_words();
        $display("summary: %0d input words, %0d result words checked, %0d moves settled",
                 words_sent, results_seen, moves_settled);
        $display("summary: %0d register writes over %0d register settings, %0d mismatches",
                 regs_written, reg_settings, mismatches);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ppml_pkg.sv
rtl/ppml_regs.sv
rtl/ppml_ctrl.sv
rtl/ppml_dpath.sv
rtl/proportional_position_motor_loop.sv
tb/sv/testbench.sv
